[src/swm_pkg.sv]
// Shared types and constants for the mid/side stereo width block.
// No dependencies; every other file but swm_fifo imports this package.
package swm_pkg;

  localparam int TGT_W      = 16;                   // width register, Q2.frac
  localparam int EXT_BITS   = 15;                   // extra fraction bits of the smoother
  localparam int GUARD_BITS = 8;                    // fraction bits kept for the product
  localparam int CW_W       = 1 + TGT_W + EXT_BITS; // signed smoothed width
  localparam int WQ_W       = TGT_W + GUARD_BITS;   // unsigned width used in the product
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd3;

  localparam logic [TGT_W-1:0] RAMP_RESET = 16'd48;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ZERO,
    OP_WIDEN
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[src/swm_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on swm_pkg for the status struct.
module swm_div import swm_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output div_stat_t     stat,
  output logic [QW-1:0] quo,
  output logic          rem_nz
);

  localparam int CNTW = $clog2(QW + 1);

  logic [DW-1:0]   rem_r, rem_nxt;
  logic [QW-1:0]   quo_r;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [NW-1:0]   num_hi;
  logic [DW:0]     trial, diff;
  logic            ge;

  // caller guarantees num < den << QW, so the upper part is already below den
  assign num_hi  = num >> QW;
  assign trial   = {rem_r, quo_r[QW-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num_hi[DW-1:0];
        quo_r  <= num[QW-1:0];
        den_r  <= den;
        cnt_r  <= CNTW'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[QW-2:0], ge};
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;
  assign rem_nz    = |rem_r;

endmodule

[src/swm_fifo.sv]
// Two-entry queue between the front and back halves.
// Depends on nothing beyond its width parameter.
module swm_fifo #(
  parameter int EW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [EW-1:0] wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic [EW-1:0] rd_data,
  output logic          empty
);

  logic [EW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (rd_en) begin
        rp_r <= ~rp_r;
      end
      case ({wr_en, rd_en})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[src/swm_front.sv]
// Front half: config registers, width smoother, item classification.
// Depends on swm_pkg and swm_div (ramp step division).
module swm_front import swm_pkg::*; #(
  parameter int SB  = 24,
  parameter int WFB = 14,
  parameter int EW  = 2 + 2 * SB + WQ_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 push,
  output logic                 full,
  input  logic [SB-1:0]        left_in,
  input  logic [SB-1:0]        right_in,
  output logic                 q_push,
  output logic [EW-1:0]        q_data,
  input  logic                 q_full
);

  localparam logic [TGT_W-1:0] TGT_RST = TGT_W'(32'd1 << WFB);
  localparam logic [CW_W-1:0]  CW_RST  = {1'b0, TGT_RST, {EXT_BITS{1'b0}}};
  localparam int               SNW     = CW_W - 1;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_UPD,
    F_PUSH
  } fstate_t;

  fstate_t           state_r;
  logic [TGT_W-1:0]  ramp_steps_r, latched_r, steps_left_r, steps_nxt;
  logic              bypass_r, rate_valid_r, pending_r;
  logic [CW_W-1:0]   cw_r, width_step_r, tgt_ext, diff, diff_mag;
  op_t               op_r, op_nxt;
  logic [SB-1:0]     left_r, right_r;
  logic              accept, unity_tgt, step_start;
  div_stat_t         dstat;
  logic [SNW-1:0]    dquo;
  logic              drem_nz;

  assign accept    = push && !full;
  assign full      = state_r != F_IDLE;
  assign tgt_ext   = {1'b0, latched_r, {EXT_BITS{1'b0}}};
  assign unity_tgt = {16'd0, latched_r} == (32'd1 << WFB);
  assign steps_nxt = steps_left_r - TGT_W'(1);

  always_comb begin
    if (bypass_r) begin
      op_nxt = OP_PASS;
    end else if (!rate_valid_r) begin
      op_nxt = OP_ZERO;
    end else if (steps_left_r == '0 && unity_tgt) begin
      op_nxt = OP_PASS;
    end else begin
      op_nxt = OP_WIDEN;
    end
  end

  // step = (target - current) / steps, truncated toward zero
  assign diff       = tgt_ext - cw_r;
  assign diff_mag   = diff[CW_W-1] ? (~diff + CW_W'(1)) : diff;
  assign step_start = accept && op_nxt == OP_WIDEN && pending_r;

  swm_div #(.NW(SNW), .DW(TGT_W), .QW(SNW)) u_step_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (step_start),
    .num    (diff_mag[SNW-1:0]),
    .den    (steps_left_r),
    .stat   (dstat),
    .quo    (dquo),
    .rem_nz (drem_nz)
  );

  assign q_push = state_r == F_PUSH && !q_full;
  assign q_data = {op_r, left_r, right_r, cw_r[EXT_BITS+TGT_W-1:EXT_BITS-GUARD_BITS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= F_IDLE;
      ramp_steps_r <= RAMP_RESET;
      bypass_r     <= 1'b0;
      rate_valid_r <= 1'b1;
      latched_r    <= TGT_RST;
      cw_r         <= CW_RST;
      width_step_r <= '0;
      steps_left_r <= '0;
      pending_r    <= 1'b0;
      op_r         <= OP_PASS;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (accept) begin
            op_r    <= op_nxt;
            left_r  <= left_in;
            right_r <= right_in;
            if (op_nxt != OP_WIDEN) begin
              state_r <= F_PUSH;
            end else if (pending_r) begin
              state_r <= F_DIV;
            end else begin
              state_r <= F_UPD;
            end
          end
        end
        F_DIV: begin
          if (dstat.done) begin
            width_step_r <= diff[CW_W-1] ? (~{1'b0, dquo} + CW_W'(1)) : {1'b0, dquo};
            pending_r    <= 1'b0;
            state_r      <= F_UPD;
          end
        end
        F_UPD: begin
          if (steps_left_r != '0) begin
            steps_left_r <= steps_nxt;
            cw_r <= (steps_nxt != '0) ? cw_r + width_step_r : tgt_ext;
          end
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET: begin
            if (cfg_data != latched_r) begin
              latched_r <= cfg_data;
              if (ramp_steps_r == '0) begin
                cw_r         <= {1'b0, cfg_data, {EXT_BITS{1'b0}}};
                steps_left_r <= '0;
                width_step_r <= '0;
                pending_r    <= 1'b0;
              end else begin
                // step itself is worked out when the next sample to be widened arrives
                steps_left_r <= ramp_steps_r;
                pending_r    <= 1'b1;
              end
            end
          end
          CFG_RAMP: begin
            ramp_steps_r <= cfg_data;
            cw_r         <= tgt_ext;
            steps_left_r <= '0;
            width_step_r <= '0;
            pending_r    <= 1'b0;
          end
          CFG_BYPASS: bypass_r     <= cfg_data[0];
          CFG_RATE:   rate_valid_r <= cfg_data[0];
          default:    bypass_r     <= bypass_r;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_pending_steps: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> steps_left_r != '0)
    else $error("ramp step pending with no steps left");
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIV) |-> (dstat.busy || dstat.done))
    else $error("waiting on step divider that is not running");
  a_upd_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_UPD) |-> (op_r == OP_WIDEN && !pending_r))
    else $error("smoother update without a resolved step");
`endif

endmodule

[src/swm_back.sv]
// Back half: mid/side product, 1/w scale by serial division, saturation.
// Depends on swm_pkg and swm_div; holds the result register.
module swm_back import swm_pkg::*; #(
  parameter int SB  = 24,
  parameter int WFB = 14,
  parameter int EW  = 2 + 2 * SB + WQ_W
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          q_pop,
  input  logic [EW-1:0] q_data,
  input  logic          q_empty,
  output logic          empty,
  input  logic          pop,
  output logic [SB-1:0] left_out,
  output logic [SB-1:0] right_out
);

  localparam int SW    = SB + 1;
  localparam int YW    = SB + 2;
  localparam int USH   = WFB + GUARD_BITS;
  localparam int PW    = WQ_W + 1 + SW;
  localparam int NLW   = ((PW > SW + USH) ? PW : SW + USH) + 1;
  localparam int DDW   = WQ_W + 1;
  localparam int QW    = SB + 1;
  localparam logic signed [YW-1:0] Y_MAX = {3'b000, {(SB-1){1'b1}}};
  localparam logic signed [YW-1:0] Y_MIN = {3'b111, {(SB-1){1'b0}}};

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SCALE,
    B_DIV,
    B_OUT
  } bstate_t;

  bstate_t              state_r;
  logic signed [SW-1:0] mid2_r, side2_r;
  logic [WQ_W-1:0]      wq_r;
  logic signed [NLW-1:0] nl_r, nr_r, mterm, nl_sh, nr_sh;
  logic signed [PW-1:0]  prod;
  logic signed [YW-1:0]  yl_r, yr_r;
  logic                  out_valid_r;
  logic                  out_load;
  logic [SB-1:0]         out_l_r, out_r_r;
  op_t                   e_op;
  logic [SB-1:0]         e_left, e_right;
  logic [WQ_W-1:0]       e_wq;
  logic [NLW-1:0]        nl_mag, nr_mag;
  logic                  div_start, wide;
  div_stat_t             lstat, rstat;
  logic [QW-1:0]         lquo, rquo;
  logic                  lrnz, rrnz;

  assign e_op    = op_t'(q_data[EW-1:EW-2]);
  assign e_left  = q_data[EW-3 -: SB];
  assign e_right = q_data[WQ_W+SB-1 -: SB];
  assign e_wq    = q_data[WQ_W-1:0];

  assign q_pop = state_r == B_IDLE && !q_empty;

  assign prod  = $signed({1'b0, wq_r}) * side2_r;
  assign mterm = NLW'(mid2_r) <<< USH;
  assign wide  = 32'(wq_r) > (32'd1 << USH);
  assign nl_sh = nl_r >>> (USH + 1);
  assign nr_sh = nr_r >>> (USH + 1);

  assign nl_mag    = nl_r[NLW-1] ? (~nl_r + NLW'(1)) : nl_r;
  assign nr_mag    = nr_r[NLW-1] ? (~nr_r + NLW'(1)) : nr_r;
  assign div_start = state_r == B_SCALE && wide;
  assign out_load  = state_r == B_OUT && (!out_valid_r || pop);

  // |n| < 2w * 2^SB when w is above unity, so SB+1 quotient bits suffice
  swm_div #(.NW(NLW), .DW(DDW), .QW(QW)) u_div_l (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (nl_mag),
    .den    ({wq_r, 1'b0}),
    .stat   (lstat),
    .quo    (lquo),
    .rem_nz (lrnz)
  );

  swm_div #(.NW(NLW), .DW(DDW), .QW(QW)) u_div_r (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (nr_mag),
    .den    ({wq_r, 1'b0}),
    .stat   (rstat),
    .quo    (rquo),
    .rem_nz (rrnz)
  );

  function automatic logic [SB-1:0] sat(input logic signed [YW-1:0] v);
    logic signed [YW-1:0] c;
    c = (v > Y_MAX) ? Y_MAX : ((v < Y_MIN) ? Y_MIN : v);
    return c[SB-1:0];
  endfunction

  // floor of a signed value from its magnitude quotient
  function automatic logic signed [YW-1:0] floor_fix(input logic neg,
                                                     input logic [QW-1:0] q,
                                                     input logic rnz);
    logic [YW-1:0] m;
    m = {1'b0, q} + YW'(rnz);
    return neg ? $signed(~m + YW'(1)) : $signed({1'b0, q});
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            case (e_op)
              OP_PASS: begin
                yl_r    <= {{2{e_left[SB-1]}}, e_left};
                yr_r    <= {{2{e_right[SB-1]}}, e_right};
                state_r <= B_OUT;
              end
              OP_WIDEN: begin
                mid2_r  <= $signed({e_left[SB-1], e_left}) + $signed({e_right[SB-1], e_right});
                side2_r <= $signed({e_left[SB-1], e_left}) - $signed({e_right[SB-1], e_right});
                wq_r    <= e_wq;
                state_r <= B_MUL;
              end
              default: begin
                yl_r    <= '0;
                yr_r    <= '0;
                state_r <= B_OUT;
              end
            endcase
          end
        end
        B_MUL: begin
          nl_r    <= mterm + NLW'(prod);
          nr_r    <= mterm - NLW'(prod);
          state_r <= B_SCALE;
        end
        B_SCALE: begin
          if (wide) begin
            state_r <= B_DIV;
          end else begin
            yl_r    <= nl_sh[YW-1:0];
            yr_r    <= nr_sh[YW-1:0];
            state_r <= B_OUT;
          end
        end
        B_DIV: begin
          if (lstat.done) begin
            yl_r    <= floor_fix(nl_r[NLW-1], lquo, lrnz);
            yr_r    <= floor_fix(nr_r[NLW-1], rquo, rrnz);
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_load) begin
            out_l_r <= sat(yl_r);
            out_r_r <= sat(yr_r);
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign empty     = !out_valid_r;
  assign left_out  = out_l_r;
  assign right_out = out_r_r;

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lstat.done == rstat.done)
    else $error("left and right dividers out of step");
  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (lstat.busy || lstat.done))
    else $error("waiting on scale divider that is not running");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && out_valid_r && !pop) |=> state_r == B_OUT)
    else $error("result register overwritten before pop");
`endif

endmodule

[src/stereo_width_mid_side.sv]
// Top level of the mid/side stereo width block: front, queue, back.
// Depends on swm_pkg, swm_front, swm_fifo, swm_back.
//
//  channel | ports                                 | beat taken when
//  --------+---------------------------------------+--------------------
//  input   | push, full, in_left_in, in_right_in    | push && !full
//  result  | empty, pop, out_left_out, out_right_out| pop && !empty
//  config  | cfg_we, cfg_index, cfg_data            | cfg_we
//
// Front: beats pass idle and push; widened beats update the smoother,
// and a beat starting a ramp waits on the step divider. Back: pass and zero
// beats go straight to output; widened beats pass multiply and scale, and the
// serial scale dividers when w is above unity. Two-entry queue and a result
// register let either side stall alone. Synchronous reset, no clearing pass.
module stereo_width_mid_side import swm_pkg::*; #(
  parameter int SAMPLE_BITS     = 24,
  parameter int WIDTH_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] in_left_in,
  input  logic [SAMPLE_BITS-1:0] in_right_in,
  output logic                   empty,
  input  logic                   pop,
  output logic [SAMPLE_BITS-1:0] out_left_out,
  output logic [SAMPLE_BITS-1:0] out_right_out
);

  localparam int EW = 2 + 2 * SAMPLE_BITS + WQ_W;

  logic          q_push, q_full, q_pop, q_empty;
  logic [EW-1:0] q_wdata, q_rdata;

  swm_front #(.SB(SAMPLE_BITS), .WFB(WIDTH_FRAC_BITS), .EW(EW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .left_in   (in_left_in),
    .right_in  (in_right_in),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  swm_fifo #(.EW(EW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  swm_back #(.SB(SAMPLE_BITS), .WFB(WIDTH_FRAC_BITS), .EW(EW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .empty     (empty),
    .pop       (pop),
    .left_out  (out_left_out),
    .right_out (out_right_out)
  );

endmodule

[tb/stereo_width_mid_side_tb.sv]
// Self-checking testbench for stereo_width_mid_side: queued stereo pairs in,
// widened pairs out, each checked against an in-bench width/ramp predictor.
// Depends on swm_pkg and the stereo_width_mid_side RTL.
module stereo_width_mid_side_tb;
  import swm_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int WFRAC       = 14;
  localparam logic [TGT_W-1:0] UNITY_TGT = 16'd16384;
  localparam longint UNITY_Q = longint'(1) << (WFRAC + GUARD_BITS);
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct {
    sample_t left;
    sample_t right;
  } pair_t;

  localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TARGET;
  logic [CFG_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [SAMPLE_BITS-1:0] in_left_in = '0;
  logic [SAMPLE_BITS-1:0] in_right_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic [SAMPLE_BITS-1:0] out_left_out;
  logic [SAMPLE_BITS-1:0] out_right_out;

  pair_t pending_pairs[$];
  pair_t expected_pairs[$];
  pair_t due_pair;

  // width smoother state and register copies
  longint cur_w;
  longint w_step;
  logic [TGT_W-1:0] steps_left;
  logic [TGT_W-1:0] tgt_latched;
  logic [TGT_W-1:0] ramp_len;
  logic bypass_on;
  logic rate_ok;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;

  stereo_width_mid_side i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .full         (full),
    .in_left_in   (in_left_in),
    .in_right_in  (in_right_in),
    .empty        (empty),
    .pop          (pop),
    .out_left_out (out_left_out),
    .out_right_out(out_right_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sample_t clip(longint v);
    if (v > longint'(SMAX)) return SMAX;
    if (v < longint'(SMIN)) return SMIN;
    return sample_t'(v);
  endfunction

  // division rounded toward minus infinity, positive divisor
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic void smoother_reset();
    ramp_len = RAMP_RESET;
    bypass_on = 1'b0;
    rate_ok = 1'b1;
    tgt_latched = UNITY_TGT;
    cur_w = longint'(UNITY_TGT) << EXT_BITS;
    w_step = 0;
    steps_left = '0;
  endfunction

  function automatic void retarget(logic [TGT_W-1:0] t);
    if (t == tgt_latched) return;
    tgt_latched = t;
    if (ramp_len == 0) begin
      cur_w = longint'(t) << EXT_BITS;
      steps_left = '0;
      w_step = 0;
    end else begin
      steps_left = ramp_len;
      w_step = ((longint'(t) << EXT_BITS) - cur_w) / longint'(ramp_len);
    end
  endfunction

  // expected output pair for one accepted input pair; advances the ramp
  function automatic void widen_pair(sample_t l, sample_t r);
    op_t op;
    longint wq, mid2, side2, nl, nr, den;
    pair_t res;
    if (bypass_on) op = OP_PASS;
    else if (!rate_ok) op = OP_ZERO;
    else if (steps_left == 0 && tgt_latched == UNITY_TGT) op = OP_PASS;
    else op = OP_WIDEN;
    case (op)
      OP_PASS: begin
        res.left = l;
        res.right = r;
      end
      OP_ZERO: begin
        res.left = '0;
        res.right = '0;
      end
      default: begin
        if (steps_left != 0) begin
          steps_left -= TGT_W'(1);
          if (steps_left != 0) cur_w += w_step;
          else cur_w = longint'(tgt_latched) << EXT_BITS;
        end
        wq = cur_w >>> (EXT_BITS - GUARD_BITS);
        mid2 = longint'(l) + longint'(r);
        side2 = longint'(l) - longint'(r);
        nl = mid2 * UNITY_Q + wq * side2;
        nr = mid2 * UNITY_Q - wq * side2;
        den = (wq > UNITY_Q) ? 2 * wq : 2 * UNITY_Q;
        res.left = clip(floor_div(nl, den));
        res.right = clip(floor_div(nr, den));
      end
    endcase
    expected_pairs.push_back(res);
  endfunction

  // driver: offers the oldest pending pair, holds it while full
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        widen_pair(in_left_in, in_right_in);
        void'(pending_pairs.pop_front());
      end
      if (!push || !full) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          in_left_in <= pending_pairs[0].left;
          in_right_in <= pending_pairs[0].right;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat, drives pop with stalls and hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pairs.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, got %0d / %0d", $time,
                   $signed(out_left_out), $signed(out_right_out));
        end else begin
          due_pair = expected_pairs.pop_front();
          if (out_left_out !== due_pair.left) begin
            errors++;
            $display("%0t: left_out expected %0d, got %0d", $time, due_pair.left,
                     $signed(out_left_out));
          end
          if (out_right_out !== due_pair.right) begin
            errors++;
            $display("%0t: right_out expected %0d, got %0d", $time, due_pair.right,
                     $signed(out_right_out));
          end
        end
      end
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_TARGET: retarget(val);
      CFG_RAMP: begin
        ramp_len = val;
        cur_w = longint'(tgt_latched) << EXT_BITS;
        steps_left = '0;
        w_step = 0;
      end
      CFG_BYPASS: bypass_on = val[0];
      default: rate_ok = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || push || expected_pairs.size() != 0)
      @(negedge clk);
  endtask

  function automatic void queue_pair(sample_t l, sample_t r);
    pair_t p;
    p.left = l;
    p.right = r;
    pending_pairs.push_back(p);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return SMAX;
      1: return SMIN;
      2: return sample_t'(int'($urandom_range(64)) - 32);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic void queue_random(int n);
    sample_t l;
    for (int k = 0; k < n; k++) begin
      l = pick_sample();
      case ($urandom_range(7))
        0: queue_pair(l, l);
        1: queue_pair(l, -l);
        default: queue_pair(l, pick_sample());
      endcase
    end
  endfunction

  function automatic logic [TGT_W-1:0] pick_target();
    case ($urandom_range(4))
      0: return UNITY_TGT;
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return TGT_W'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [TGT_W-1:0] pick_ramp();
    case ($urandom_range(4))
      0: return '0;
      1: return TGT_W'($urandom_range(8, 1));
      2: return TGT_W'($urandom_range(150, 9));
      3: return TGT_W'($urandom_range(400, 151));
      default: return TGT_W'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    smoother_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unity target after reset: straight pass
    queue_pair(SMAX, SMAX);
    queue_pair(SMIN, SMIN);
    queue_pair(SMAX, SMIN);
    wait_idle();
    // bypass wins over a missing rate; then zeros
    write_reg(CFG_BYPASS, 16'd1);
    write_reg(CFG_RATE, 16'd0);
    queue_pair(SMIN, SMAX);
    wait_idle();
    write_reg(CFG_BYPASS, 16'd0);
    queue_pair(SMAX, SMIN);
    wait_idle();
    write_reg(CFG_RATE, 16'd1);
    // snap to widest: scaled by 1/w, rounding down on negatives
    write_reg(CFG_RAMP, 16'd0);
    write_reg(CFG_TARGET, 16'hFFFF);
    queue_pair(SMAX, SMIN);
    queue_pair(SMIN, SMAX);
    queue_pair(SMAX, SMAX);
    queue_pair(sample_t'(-1), sample_t'(0));
    queue_pair(sample_t'(0), sample_t'(-1));
    wait_idle();
    // zero width: mono, then a rewrite of the same target does nothing
    write_reg(CFG_TARGET, 16'h0000);
    write_reg(CFG_TARGET, 16'h0000);
    queue_pair(SMAX, SMIN);
    queue_pair(SMIN, SMIN);
    queue_pair(sample_t'(-1), sample_t'(0));
    wait_idle();
    // short ramp up to half width, running past its end
    write_reg(CFG_RAMP, 16'd4);
    write_reg(CFG_TARGET, 16'd8192);
    queue_pair(SMAX, SMIN);
    queue_pair(sample_t'(1000), sample_t'(-3000));
    queue_pair(sample_t'(-5), sample_t'(7));
    queue_pair(SMIN, sample_t'(12345));
    queue_pair(sample_t'(-777777), sample_t'(4242));
    wait_idle();
    // longest ramp toward unity, then a ramp write snaps it there
    write_reg(CFG_RAMP, 16'hFFFF);
    write_reg(CFG_TARGET, UNITY_TGT);
    queue_pair(SMAX, SMIN);
    queue_pair(sample_t'(-3), sample_t'(2));
    wait_idle();
    write_reg(CFG_RAMP, 16'd0);
    queue_pair(SMIN, SMAX);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_TARGET, pick_target());
      end else if ($urandom_range(1)) begin
        write_reg(CFG_RAMP, pick_ramp());
        write_reg(CFG_TARGET, pick_target());
      end else begin
        write_reg(CFG_TARGET, pick_target());
        write_reg(CFG_RAMP, pick_ramp());
      end
      write_reg(CFG_BYPASS, CFG_W'($urandom_range(7) == 0));
      write_reg(CFG_RATE, CFG_W'($urandom_range(7) != 0));
      // long receiver hold-off while the sender keeps offering
      if (p == 4) hold_token++;
      queue_random(115);
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
